// ----- src/date_string_field_parser_assert.svh -----
// Assertion macros for the date string field parser.
`ifndef DATE_STRING_FIELD_PARSER_ASSERT_SVH
`define DATE_STRING_FIELD_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define DSFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsfp: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define DSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsfp: next-cycle check failed");
`else
`define DSFP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/dsfp_pkg.sv -----
// Types, constants and year-close arithmetic for the date string field parser.
package dsfp_pkg;

	localparam int unsigned NumFields = 5;

	typedef logic [13:0] field_t;
	typedef logic [2:0]  fidx_t;
	typedef logic [3:0]  ccount_t;
	typedef logic [2:0]  lead_t;
	typedef logic [6:0]  century_t;
	typedef logic [7:0]  char_t;

	localparam fidx_t FIELD_YEAR = 3'd0;
	localparam fidx_t FIELD_DAY  = 3'd1;
	localparam fidx_t FIELD_HOUR = 3'd2;
	localparam fidx_t FIELD_MIN  = 3'd3;
	localparam fidx_t FIELD_SEC  = 3'd4;

	localparam field_t   FIELD_MAX     = 14'd9999;
	localparam ccount_t  YEAR_FULL_LEN = 4'd4;
	localparam ccount_t  CCOUNT_MAX    = 4'd15;
	localparam lead_t    LEAD_MAX      = 3'd7;
	localparam century_t CENTURY_MAX   = 7'd99;
	localparam century_t CENTURY_RESET = 7'd20;

	localparam char_t CHAR_NUL   = 8'h00;
	localparam char_t CHAR_COMMA = 8'h2C;
	localparam char_t CHAR_COLON = 8'h3A;
	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_NINE  = 8'h39;

	typedef struct packed {
		field_t value;
		logic   err;
	} year_close_t;

	// Prefix the century to a short year field. Century times 10^lead saturates
	// once lead reaches four digits (century is at least one there).
	function automatic year_close_t year_close(century_t century, ccount_t cnt,
			lead_t lead, field_t acc, logic ovf);
		year_close_t res;
		century_t    cent;
		logic [9:0]  mult;
		logic [16:0] scaled;
		logic [17:0] sum;
		logic        big;
		cent = (century > CENTURY_MAX) ? CENTURY_MAX : century;
		unique case (lead[1:0])
			2'd0:    mult = 10'd1;
			2'd1:    mult = 10'd10;
			2'd2:    mult = 10'd100;
			default: mult = 10'd1000;
		endcase
		scaled = 17'(cent) * 17'(mult);
		big    = lead[2] || (scaled > 17'(FIELD_MAX));
		sum    = 18'(scaled) + 18'(acc);
		if (cnt == YEAR_FULL_LEN || cent == '0) begin
			res.value = acc;
			res.err   = ovf;
		end else if (big || ovf || sum > 18'(FIELD_MAX)) begin
			res.value = FIELD_MAX;
			res.err   = 1'b1;
		end else begin
			res.value = sum[13:0];
			res.err   = 1'b0;
		end
		return res;
	endfunction

endpackage

// ----- src/date_string_field_parser.sv -----
// Date string field parser: year,day,hour:minute:second characters in, fields out.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  in       | in_valid / in_ready  | char_code
//  out      | out_valid / out_ready| year_value, day_of_year, hour_value,
//           |                      | minute_value, second_value, format_error
//  config   | cfg_wr_en            | cfg_wr_data (century digits)
//
// One character per cycle sustained while no terminator waits. An accepted
// item lands in the input register and is parsed from there; a terminator's
// result is loaded into the output register at the end of the cycle in which
// it is parsed, and out_valid rises with it.
// Reset (arst_n low) clears the parse state and sets the century to 20.
// Only a terminator waits on the output side: it holds in the input register
// while a result is still untaken, and the characters behind it wait in turn.
`include "date_string_field_parser_assert.svh"

module date_string_field_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  dsfp_pkg::century_t  cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsfp_pkg::char_t     char_code,
	output logic                out_valid,
	input  logic                out_ready,
	output dsfp_pkg::field_t    year_value,
	output dsfp_pkg::field_t    day_of_year,
	output dsfp_pkg::field_t    hour_value,
	output dsfp_pkg::field_t    minute_value,
	output dsfp_pkg::field_t    second_value,
	output logic                format_error
);

	// Century register
	dsfp_pkg::century_t cent_q;

	// Input register
	logic               valid_s1;
	dsfp_pkg::char_t    char_s1;

	// Parse state
	dsfp_pkg::fidx_t    fidx_q, fidx_n;
	dsfp_pkg::field_t   acc_q [dsfp_pkg::NumFields];
	dsfp_pkg::field_t   acc_n [dsfp_pkg::NumFields];
	dsfp_pkg::ccount_t  cnt_q, cnt_n;
	dsfp_pkg::lead_t    lead_q, lead_n;
	logic               stop_q, stop_n;
	logic               err_q, err_n;
	logic               ovf_q, ovf_n;

	// Output register
	logic               out_valid_q;
	dsfp_pkg::field_t   year_q, day_q, hour_q, min_q, sec_q;
	logic               ferr_q;

	// Datapath
	logic                   fire;
	logic                   is_term, is_digit, is_sep;
	dsfp_pkg::fidx_t        fi;
	dsfp_pkg::field_t       acc_cur;
	logic [16:0]            digit_acc;
	logic                   digit_over;
	dsfp_pkg::year_close_t  yclose;
	logic                   term_close;
	dsfp_pkg::field_t       year_res;
	logic                   err_res;

	// The input register moves on unless it holds a terminator and the
	// output register is full and not being drained.
	assign is_term  = (char_s1 == dsfp_pkg::CHAR_NUL);
	assign fire     = valid_s1 && (!is_term || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	assign fi       = (fidx_q > dsfp_pkg::FIELD_SEC) ? dsfp_pkg::FIELD_SEC : fidx_q;
	assign acc_cur  = acc_q[fi];
	assign is_digit = (char_s1 >= dsfp_pkg::CHAR_ZERO) && (char_s1 <= dsfp_pkg::CHAR_NINE);
	assign is_sep   = (((fi == dsfp_pkg::FIELD_YEAR) || (fi == dsfp_pkg::FIELD_DAY))
			&& (char_s1 == dsfp_pkg::CHAR_COMMA))
		|| (((fi == dsfp_pkg::FIELD_HOUR) || (fi == dsfp_pkg::FIELD_MIN))
			&& (char_s1 == dsfp_pkg::CHAR_COLON));

	// acc*10 + digit; at most 99999, so 17 bits hold it
	assign digit_acc  = 17'(acc_cur) * 17'd10 + 17'(char_s1[3:0]);
	assign digit_over = digit_acc > 17'(dsfp_pkg::FIELD_MAX);

	assign yclose = dsfp_pkg::year_close(cent_q, cnt_q, lead_q, acc_q[0], ovf_q);

	// Terminator inside the year field: close the year as a comma would,
	// and flag the missing comma. An empty string skips this.
	assign term_close = (fi == dsfp_pkg::FIELD_YEAR) && (cnt_q != '0);
	assign year_res   = term_close ? yclose.value : acc_q[0];
	assign err_res    = term_close ? 1'b1 : err_q;

	always_comb begin
		fidx_n = fidx_q;
		cnt_n  = cnt_q;
		lead_n = lead_q;
		stop_n = stop_q;
		err_n  = err_q;
		ovf_n  = ovf_q;
		for (int i = 0; i < dsfp_pkg::NumFields; i++) begin
			acc_n[i] = acc_q[i];
		end
		if (fire) begin
			if (is_term) begin
				// result goes out; start over for the next string
				fidx_n = dsfp_pkg::FIELD_YEAR;
				cnt_n  = '0;
				lead_n = '0;
				stop_n = 1'b0;
				err_n  = 1'b0;
				ovf_n  = 1'b0;
				for (int i = 0; i < dsfp_pkg::NumFields; i++) begin
					acc_n[i] = '0;
				end
			end else begin
				// year character count; the comma itself does not count
				if ((fi == dsfp_pkg::FIELD_YEAR) && !is_sep
						&& (cnt_q < dsfp_pkg::CCOUNT_MAX)) begin
					cnt_n = cnt_q + 4'd1;
				end
				priority if (is_sep) begin
					if (fi == dsfp_pkg::FIELD_YEAR) begin
						acc_n[0] = yclose.value;
						err_n    = err_q | yclose.err;
					end
					fidx_n = fi + 3'd1;
					stop_n = 1'b0;
				end else if (!stop_q && is_digit) begin
					if (digit_over) begin
						acc_n[fi] = dsfp_pkg::FIELD_MAX;
						if (fi == dsfp_pkg::FIELD_YEAR) begin
							ovf_n = 1'b1;
						end else begin
							err_n = 1'b1;
						end
					end else begin
						acc_n[fi] = digit_acc[13:0];
					end
					if ((fi == dsfp_pkg::FIELD_YEAR) && (lead_q < dsfp_pkg::LEAD_MAX)) begin
						lead_n = lead_q + 3'd1;
					end
				end else begin
					stop_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cent_q      <= dsfp_pkg::CENTURY_RESET;
			valid_s1    <= 1'b0;
			fidx_q      <= dsfp_pkg::FIELD_YEAR;
			cnt_q       <= '0;
			lead_q      <= '0;
			stop_q      <= 1'b0;
			err_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < dsfp_pkg::NumFields; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				cent_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			fidx_q <= fidx_n;
			cnt_q  <= cnt_n;
			lead_q <= lead_n;
			stop_q <= stop_n;
			err_q  <= err_n;
			ovf_q  <= ovf_n;
			for (int i = 0; i < dsfp_pkg::NumFields; i++) begin
				acc_q[i] <= acc_n[i];
			end
			if (fire && is_term) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
		if (fire && is_term) begin
			year_q <= year_res;
			day_q  <= acc_q[1];
			hour_q <= acc_q[2];
			min_q  <= acc_q[3];
			sec_q  <= acc_q[4];
			ferr_q <= err_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign year_value   = year_q;
	assign day_of_year  = day_q;
	assign hour_value   = hour_q;
	assign minute_value = min_q;
	assign second_value = sec_q;
	assign format_error = ferr_q;

	// A processed terminator always produces a result and clears the parse state.
	`DSFP_ASSERT_NEXT(a_term_result, clk, arst_n, fire && is_term, out_valid_q)
	`DSFP_ASSERT_NEXT(a_term_clears, clk, arst_n, fire && is_term, (fidx_q == dsfp_pkg::FIELD_YEAR) && (cnt_q == '0) && !err_q && !ovf_q)
	// Errors before the first comma live in the overflow bit, never in err_q.
	`DSFP_ASSERT_IMPL(a_err_after_year, clk, arst_n, err_q, fidx_q != dsfp_pkg::FIELD_YEAR)
	// Field index never runs past the seconds field.
	`DSFP_ASSERT_IMPL(a_fidx_range, clk, arst_n, fire && is_sep, fidx_q != dsfp_pkg::FIELD_SEC)

endmodule

// ----- tb/tb_date_string_field_parser.sv -----
// Self-checking testbench for the date string field parser.
module tb_date_string_field_parser;
	timeunit 1ns;
	timeprecision 1ps;

	// Run bounds. The worst correct run, with idle gaps between items, stalled
	// results and one long hold, stays under CYCLE_LIMIT.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// Settling margin after the last result, before a config write.
	localparam int          DRAIN_CYCLES = 4;
	// Long receiver hold used to back the block up into its input.
	localparam int          HOLD_CYCLES  = 300;
	localparam int          PHASE_ITEMS  = 260;
	localparam int          LAST_ITEMS   = 240;

	// One parsed date as it leaves the block.
	typedef struct packed {
		dsfp_pkg::field_t yr;
		dsfp_pkg::field_t doy;
		dsfp_pkg::field_t hr;
		dsfp_pkg::field_t mn;
		dsfp_pkg::field_t sc;
		logic             err;
	} date_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	dsfp_pkg::century_t cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	dsfp_pkg::char_t    char_code;
	logic               out_valid;
	logic               out_ready = 1'b0;
	dsfp_pkg::field_t   year_value;
	dsfp_pkg::field_t   day_of_year;
	dsfp_pkg::field_t   hour_value;
	dsfp_pkg::field_t   minute_value;
	dsfp_pkg::field_t   second_value;
	logic               format_error;

	date_string_field_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year_value   (year_value),
		.day_of_year  (day_of_year),
		.hour_value   (hour_value),
		.minute_value (minute_value),
		.second_value (second_value),
		.format_error (format_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parser prediction: its own copy of the century register and of the
	// parse state, advanced once per accepted item.
	// ------------------------------------------------------------------
	date_result_t pending_dates[$];

	dsfp_pkg::century_t century_reg;
	dsfp_pkg::fidx_t    cur_field;
	dsfp_pkg::field_t   fld_acc[dsfp_pkg::NumFields];
	dsfp_pkg::ccount_t  year_len;      // bytes seen in the year field, saturating
	dsfp_pkg::lead_t    year_digits;   // digits actually read into the year, saturating
	bit                 year_sat;      // year digits ran past 9999
	bit                 digits_off;    // a non-digit stopped reading in this field
	bit                 err_flag;

	int unsigned     mismatches;
	int unsigned     chars_sent;
	bit              src_idle_on;
	dsfp_pkg::char_t date_buf[$];

	function void clear_parse_state();
		cur_field   = dsfp_pkg::FIELD_YEAR;
		year_len    = '0;
		year_digits = '0;
		year_sat    = 1'b0;
		digits_off  = 1'b0;
		err_flag    = 1'b0;
		foreach (fld_acc[i])
			fld_acc[i] = '0;
	endfunction

	// Year closes: a year field that is not exactly four bytes long gets the century
	// digits in front unless the century is zero, i.e. century * 10^digits + value.
	function void close_year_field();
		int cent;
		int prefixed;
		cent = (century_reg > dsfp_pkg::CENTURY_MAX) ? int'(dsfp_pkg::CENTURY_MAX)
			: int'(century_reg);
		if (year_len == dsfp_pkg::YEAR_FULL_LEN || cent == 0) begin
			if (year_sat)
				err_flag = 1'b1;
			return;
		end
		prefixed = cent;
		for (int i = 0; i < int'(year_digits); i++) begin
			prefixed = prefixed * 10;
			if (prefixed > int'(dsfp_pkg::FIELD_MAX))
				prefixed = int'(dsfp_pkg::FIELD_MAX) + 1;
		end
		prefixed = prefixed + int'(fld_acc[dsfp_pkg::FIELD_YEAR]);
		if (prefixed > int'(dsfp_pkg::FIELD_MAX) || year_sat) begin
			prefixed = int'(dsfp_pkg::FIELD_MAX);
			err_flag = 1'b1;
		end
		fld_acc[dsfp_pkg::FIELD_YEAR] = dsfp_pkg::field_t'(prefixed);
	endfunction

	function void parse_char(input dsfp_pkg::char_t c);
		date_result_t res;
		int           fi;
		int           v;
		fi = int'(cur_field);
		if (c == dsfp_pkg::CHAR_NUL) begin
			if (cur_field == dsfp_pkg::FIELD_YEAR) begin
				if (year_len == '0) begin
					foreach (fld_acc[i])
						fld_acc[i] = '0;
					err_flag = 1'b0;
				end else begin
					// string ended inside the year: close it, flag missing comma
					close_year_field();
					err_flag = 1'b1;
				end
			end
			res.yr  = fld_acc[dsfp_pkg::FIELD_YEAR];
			res.doy = fld_acc[dsfp_pkg::FIELD_DAY];
			res.hr  = fld_acc[dsfp_pkg::FIELD_HOUR];
			res.mn  = fld_acc[dsfp_pkg::FIELD_MIN];
			res.sc  = fld_acc[dsfp_pkg::FIELD_SEC];
			res.err = err_flag;
			pending_dates.push_back(res);
			clear_parse_state();
			return;
		end
		if (cur_field == dsfp_pkg::FIELD_YEAR && year_len < dsfp_pkg::CCOUNT_MAX)
			year_len = year_len + 1'b1;
		// Right separator for the current field moves on to the next field.
		if (((cur_field == dsfp_pkg::FIELD_YEAR || cur_field == dsfp_pkg::FIELD_DAY)
				&& c == dsfp_pkg::CHAR_COMMA) ||
				((cur_field == dsfp_pkg::FIELD_HOUR || cur_field == dsfp_pkg::FIELD_MIN)
				&& c == dsfp_pkg::CHAR_COLON)) begin
			if (cur_field == dsfp_pkg::FIELD_YEAR) begin
				year_len = year_len - 1'b1;
				close_year_field();
			end
			cur_field  = cur_field + 1'b1;
			digits_off = 1'b0;
			return;
		end
		if (!digits_off && c >= dsfp_pkg::CHAR_ZERO && c <= dsfp_pkg::CHAR_NINE) begin
			v = int'(fld_acc[fi]) * 10 + int'(c) - int'(dsfp_pkg::CHAR_ZERO);
			if (v > int'(dsfp_pkg::FIELD_MAX)) begin
				v = int'(dsfp_pkg::FIELD_MAX);
				if (cur_field == dsfp_pkg::FIELD_YEAR)
					year_sat = 1'b1;
				else
					err_flag = 1'b1;
			end
			fld_acc[fi] = dsfp_pkg::field_t'(v);
			if (cur_field == dsfp_pkg::FIELD_YEAR && year_digits < dsfp_pkg::LEAD_MAX)
				year_digits = year_digits + 1'b1;
		end else begin
			digits_off = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stall bursts, plus a long hold on request.
	// ------------------------------------------------------------------
	bit   sink_idle_on = 1'b1;
	bit   sink_holding = 1'b0;
	int   sink_gap;
	event sink_hold_start;

	// The hold counts its own cycles so the sender keeps offering items.
	initial begin
		forever begin
			@(sink_hold_start);
			sink_holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_gap  <= 0;
		end else if (sink_holding) begin
			out_ready <= 1'b0;
		end else if (sink_gap != 0) begin
			out_ready <= 1'b0;
			sink_gap  <= sink_gap - 1;
		end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
			// start a stall burst; sink_gap holds its remaining length
			out_ready <= 1'b0;
			sink_gap  <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Every taken result is compared against the oldest pending date.
	always @(posedge clk) begin : check_results
		date_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no date pending", 1, 0);
			end else begin
				want = pending_dates.pop_front();
				if (year_value !== want.yr)
					report_mismatch("year_value", int'(year_value), int'(want.yr));
				if (day_of_year !== want.doy)
					report_mismatch("day_of_year", int'(day_of_year), int'(want.doy));
				if (hour_value !== want.hr)
					report_mismatch("hour_value", int'(hour_value), int'(want.hr));
				if (minute_value !== want.mn)
					report_mismatch("minute_value", int'(minute_value), int'(want.mn));
				if (second_value !== want.sc)
					report_mismatch("second_value", int'(second_value), int'(want.sc));
				if (format_error !== want.err)
					report_mismatch("format_error", int'(format_error), int'(want.err));
			end
		end
	end

	// Watchdog.
	int unsigned cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sending side. Valid stays high between back-to-back items; it only
	// drops for an idle burst or when the stream pauses.
	// ------------------------------------------------------------------
	task automatic send_char(input dsfp_pkg::char_t c);
		int gap;
		gap = 0;
		if (src_idle_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do
			@(posedge clk);
		while (!in_ready);
		parse_char(c);
		chars_sent++;
	endtask

	// Sends the text and then the terminating zero.
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(dsfp_pkg::char_t'(s[i]));
		send_char(dsfp_pkg::CHAR_NUL);
	endtask

	// Wait for every pending date, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_century(input dsfp_pkg::century_t v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		century_reg = v;
	endtask

	// Random digits with many zeros and nines, and now and then a stray byte.
	task automatic push_digits(input int len);
		int r;
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				date_buf.push_back(dsfp_pkg::char_t'($urandom_range(1, 255)));
			else if (r < 14)
				date_buf.push_back(dsfp_pkg::CHAR_ZERO);
			else if (r < 24)
				date_buf.push_back(dsfp_pkg::CHAR_NINE);
			else
				date_buf.push_back(dsfp_pkg::CHAR_ZERO
					+ dsfp_pkg::char_t'($urandom_range(0, 9)));
		end
	endtask

	// Separator in front of field f; sometimes the wrong kind or junk.
	task automatic push_separator(input int f);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			date_buf.push_back(dsfp_pkg::char_t'($urandom_range(1, 255)));
		else if (r < 12)
			date_buf.push_back((f <= 2) ? dsfp_pkg::CHAR_COLON : dsfp_pkg::CHAR_COMMA);
		else
			date_buf.push_back((f <= 2) ? dsfp_pkg::CHAR_COMMA : dsfp_pkg::CHAR_COLON);
	endtask

	task automatic send_random_date();
		int pick;
		int n_fields;
		int r;
		date_buf.delete();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// plain noise
			repeat ($urandom_range(0, 12))
				date_buf.push_back(dsfp_pkg::char_t'($urandom_range(1, 255)));
		end else begin
			n_fields = (pick < 60) ? 5 : $urandom_range(1, 4);
			// year: often four bytes, else short or long
			r = $urandom_range(0, 11);
			push_digits((r < 4) ? r : (r < 8) ? 4 : r - 3);
			for (int f = 1; f < n_fields; f++) begin
				push_separator(f);
				r = $urandom_range(0, 9);
				push_digits((r < 1) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6));
			end
		end
		date_buf.push_back(dsfp_pkg::CHAR_NUL);
		foreach (date_buf[i])
			send_char(date_buf[i]);
	endtask

	task automatic run_random_dates(input int n_items);
		int stop_at;
		stop_at = chars_sent + n_items;
		while (chars_sent < stop_at)
			send_random_date();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset century of 20: empty string, then a short year with a leading
	// zero and a comma where the minute should end with a colon.
	task automatic test_reset_defaults();
		send_text("");
		send_text("07,9,1:2,3");
	endtask

	// No comma with an overlong year, and an overlong day.
	task automatic test_field_overflow();
		send_text("12345");
		send_text("1,99999");
	endtask

	// Century zero disables the prefix; values above 99 clamp to 99.
	task automatic test_century_limits();
		set_century(dsfp_pkg::century_t'(0));
		send_text("5,");
		set_century(dsfp_pkg::century_t'(127));
		send_text("5,");
		set_century(dsfp_pkg::CENTURY_MAX);
		send_text("123,");
	endtask

	// Receiver holds off while short strings keep coming: the output
	// register fills, the next terminator parks and the input stalls.
	task automatic test_output_backpressure();
		wait_idle();
		src_idle_on = 1'b0;
		-> sink_hold_start;
		repeat (16) begin
			if ($urandom_range(0, 1) != 0)
				send_text("");
			else
				send_text("4,5");
		end
		wait_idle();
		src_idle_on = 1'b1;
	endtask

	task automatic test_random_centuries();
		set_century(dsfp_pkg::century_t'($urandom_range(1, 98)));
		run_random_dates(PHASE_ITEMS);
		set_century(dsfp_pkg::century_t'(0));
		run_random_dates(PHASE_ITEMS);
		set_century(dsfp_pkg::CENTURY_MAX);
		run_random_dates(PHASE_ITEMS);
		set_century(dsfp_pkg::century_t'(127));
		run_random_dates(PHASE_ITEMS);
		set_century(dsfp_pkg::century_t'(100));
		run_random_dates(PHASE_ITEMS);
		set_century(dsfp_pkg::CENTURY_RESET);
		run_random_dates(PHASE_ITEMS);
	endtask

	// Last stretch: both sides at full rate.
	task automatic test_steady_stream();
		wait_idle();
		src_idle_on = 1'b0;
		sink_idle_on <= 1'b0;
		set_century(dsfp_pkg::century_t'($urandom_range(1, 99)));
		run_random_dates(LAST_ITEMS);
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= '0;
		in_valid     <= 1'b0;
		char_code    <= '0;
		src_idle_on  = 1'b1;
		mismatches   = 0;
		chars_sent   = 0;
		century_reg  = dsfp_pkg::CENTURY_RESET;
		clear_parse_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_overflow();
		test_century_limits();
		test_output_backpressure();
		test_random_centuries();
		test_steady_stream();

		wait_idle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/dsfp_pkg.sv
src/date_string_field_parser.sv
tb/tb_date_string_field_parser.sv
